### rtl/cc20_pkg.sv
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and helpers of the ChaCha20 stream cipher core.
// ----------------------------------------------------------------------------
package cc20_pkg;

    // Sixteen 32-bit state words, word 0 in the low bits.
    typedef logic [15:0][31:0] t_words;

    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W   = 4;
    localparam int DATA_W    = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE0 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE1 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ICTR   = 3'd6;

    // "expand 32-byte k"
    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    typedef enum logic [2:0] {
        S_IDLE,
        S_XOR,
        S_GEN,
        S_WAIT,
        S_OUT
    } t_state;

    // Request from the sequencer to the block function.
    typedef struct packed {
        logic   start;
        t_words init;
    } t_blk_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_blk_stat;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic t_words make_init(
        input logic [63:0] key0,
        input logic [63:0] key1,
        input logic [63:0] key2,
        input logic [63:0] key3,
        input logic [63:0] nonce0,
        input logic [31:0] nonce1,
        input logic [31:0] ctr
    );
        t_words w;
        w[0]  = SIGMA0;
        w[1]  = SIGMA1;
        w[2]  = SIGMA2;
        w[3]  = SIGMA3;
        w[4]  = key0[31:0];
        w[5]  = key0[63:32];
        w[6]  = key1[31:0];
        w[7]  = key1[63:32];
        w[8]  = key2[31:0];
        w[9]  = key2[63:32];
        w[10] = key3[31:0];
        w[11] = key3[63:32];
        w[12] = ctr;
        w[13] = nonce0[31:0];
        w[14] = nonce0[63:32];
        w[15] = nonce1;
        return w;
    endfunction

endpackage

### rtl/cc20_ifs.sv
// ----------------------------------------------------------------------------
// cc20 channel interfaces
// Valid/ready channels for message items, result items and register writes.
// ----------------------------------------------------------------------------
interface cc20_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_bytes;
    logic [3:0]  byte_count;
    logic        first_of_message;

    modport source (output valid, data_bytes, byte_count, first_of_message, input ready);
    modport sink   (input valid, data_bytes, byte_count, first_of_message, output ready);
endinterface

interface cc20_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] cipher_bytes;
    logic [3:0]  cipher_count;

    modport source (output valid, cipher_bytes, cipher_count, input ready);
    modport sink   (input valid, cipher_bytes, cipher_count, output ready);
endinterface

interface cc20_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/cc20_qround.sv
// ----------------------------------------------------------------------------
// cc20_qround
// One ChaCha quarter round lane on four 32-bit words.
// ----------------------------------------------------------------------------
module cc20_qround (
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    input  logic [31:0] i_d,
    output logic [31:0] o_a,
    output logic [31:0] o_b,
    output logic [31:0] o_c,
    output logic [31:0] o_d
);
    import cc20_pkg::*;

    logic [31:0] a1, b1, c1, d1;
    logic [31:0] a2, b2, c2, d2;

    always_comb begin
        a1 = i_a + i_b;
        d1 = rotl(i_d ^ a1, 16);
        c1 = i_c + d1;
        b1 = rotl(i_b ^ c1, 12);
        a2 = a1 + b1;
        d2 = rotl(d1 ^ a2, 8);
        c2 = c1 + d2;
        b2 = rotl(b1 ^ c2, 7);
    end

    assign o_a = a2;
    assign o_b = b2;
    assign o_c = c2;
    assign o_d = d2;

endmodule

### rtl/cc20_core.sv
// ----------------------------------------------------------------------------
// cc20_core
// Block function: four quarter round lanes run one round per cycle, then a
// merging stage adds the input state back in to form the keystream block.
// ----------------------------------------------------------------------------
module cc20_core #(
    parameter int ROUNDS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cc20_pkg::t_blk_req  i_req,
    output cc20_pkg::t_blk_stat o_stat,
    output cc20_pkg::t_words    o_keystream
);
    import cc20_pkg::*;

    localparam int RW = $clog2(ROUNDS);

    t_words          r_state;
    t_words          n_state;
    t_words          r_init;
    t_words          r_ks;
    logic [RW-1:0]   r_round;
    logic            r_busy;
    logic            r_merge;
    logic            r_done;
    logic            diag;

    logic [3:0][31:0] qa_in, qb_in, qc_in, qd_in;
    logic [3:0][31:0] qa_out, qb_out, qc_out, qd_out;

    // Odd rounds use the diagonals: lane k takes words k, 4+(k+1)%4, 8+(k+2)%4, 12+(k+3)%4.
    assign diag = r_round[0];

    always_comb begin
        logic [1:0] kb, kc, kd;
        for (int k = 0; k < 4; k++) begin
            kb = 2'(k) + {1'b0, diag};
            kc = 2'(k) + {diag, 1'b0};
            kd = 2'(k) + {diag, diag};
            qa_in[k] = r_state[{2'd0, 2'(k)}];
            qb_in[k] = r_state[{2'd1, kb}];
            qc_in[k] = r_state[{2'd2, kc}];
            qd_in[k] = r_state[{2'd3, kd}];
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_lane
        cc20_qround u_qround (
            .i_a (qa_in[k]),
            .i_b (qb_in[k]),
            .i_c (qc_in[k]),
            .i_d (qd_in[k]),
            .o_a (qa_out[k]),
            .o_b (qb_out[k]),
            .o_c (qc_out[k]),
            .o_d (qd_out[k])
        );
    end

    always_comb begin
        logic [1:0] kb, kc, kd;
        n_state = r_state;
        for (int k = 0; k < 4; k++) begin
            kb = 2'(k) + {1'b0, diag};
            kc = 2'(k) + {diag, 1'b0};
            kd = 2'(k) + {diag, diag};
            n_state[{2'd0, 2'(k)}] = qa_out[k];
            n_state[{2'd1, kb}]    = qb_out[k];
            n_state[{2'd2, kc}]    = qc_out[k];
            n_state[{2'd3, kd}]    = qd_out[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_merge <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done  <= r_merge;
            r_merge <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 1'b1;
                if (r_round == RW'(ROUNDS - 1)) begin
                    r_busy  <= 1'b0;
                    r_merge <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_state <= i_req.init;
            r_init  <= i_req.init;
        end else if (r_busy) begin
            r_state <= n_state;
        end
        if (r_merge) begin
            for (int w = 0; w < 16; w++) begin
                r_ks[w] <= r_state[w] + r_init[w];
            end
        end
    end

    assign o_stat.busy = r_busy | r_merge;
    assign o_stat.done = r_done;
    assign o_keystream = r_ks;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy && !r_merge)
        else $error("block start while a block is in progress");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_round <= RW'(ROUNDS - 1))
        else $error("round counter out of range");

    a_done_after_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_merge |=> r_done && !r_merge)
        else $error("merge not followed by done");

endmodule

### rtl/chacha20_stream_cipher_core.sv
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_core
// ChaCha20 (96-bit nonce, 32-bit block counter) stream encryption of items of
// up to eight bytes.
// ----------------------------------------------------------------------------
// Usage:
//   i_cfg writes the key, nonce and initial counter registers; it is always
//   ready and should be used only while no item is in flight.
//   i_in takes one item at a time: data bytes, byte count and a first mark
//   that reloads the block counter and restarts the keystream position.
//   o_out returns one item per input item, with bytes above the count zero.
// Steps: an item whose bytes sit in the current keystream block passes
//   through accept, XOR and hand-off to the output register. When a new
//   block is needed, these steps come between: finding the block missing,
//   the request, one round per cycle in four quarter round lanes, the
//   add-back and taking the finished block.
// Stall: the output register holds one result; the next item is accepted
//   and worked on while it waits, and the sequencer holds before its own
//   hand-off until the register is free.
// Reset: config registers, counter and position zero; no keystream block.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_core #(
    parameter int ROUNDS     = 20,
    parameter int LANE_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cc20_cfg_if.sink    i_cfg,
    cc20_in_if.sink     i_in,
    cc20_out_if.source  o_out
);
    import cc20_pkg::*;

    localparam logic [COUNT_W-1:0] LB = COUNT_W'(LANE_BYTES);

    t_state              r_state, n_state;

    logic [63:0]         r_key0, r_key1, r_key2, r_key3, r_nonce0;
    logic [31:0]         r_nonce1, r_ictr;

    logic [DATA_W-1:0]   r_data, n_data;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [COUNT_W-1:0]  r_done, n_done;
    logic [DATA_W-1:0]   r_res, n_res;
    logic [31:0]         r_ctr, n_ctr;
    logic [5:0]          r_pos, n_pos;
    logic                r_ksv, n_ksv;
    logic                r_ov, n_ov;
    logic [DATA_W-1:0]   r_cb, n_cb;
    logic [COUNT_W-1:0]  r_cc, n_cc;

    logic                in_acc;
    logic                out_free;
    logic [COUNT_W-1:0]  sat_count;
    logic [COUNT_W-1:0]  rem;
    logic [6:0]          avail;
    logic [COUNT_W-1:0]  chunk;
    logic [6:0]          pos_sum;
    logic                last_chunk;
    logic [511:0]        ks_flat;

    t_blk_req            blk_req;
    t_blk_stat           blk_stat;
    t_words              keystream;

    cc20_core #(.ROUNDS(ROUNDS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (blk_req),
        .o_stat      (blk_stat),
        .o_keystream (keystream)
    );

    assign ks_flat = keystream;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0   <= '0;
            r_key1   <= '0;
            r_key2   <= '0;
            r_key3   <= '0;
            r_nonce0 <= '0;
            r_nonce1 <= '0;
            r_ictr   <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_KEY0:   r_key0   <= i_cfg.data;
                CFG_KEY1:   r_key1   <= i_cfg.data;
                CFG_KEY2:   r_key2   <= i_cfg.data;
                CFG_KEY3:   r_key3   <= i_cfg.data;
                CFG_NONCE0: r_nonce0 <= i_cfg.data;
                CFG_NONCE1: r_nonce1 <= i_cfg.data[31:0];
                CFG_ICTR:   r_ictr   <= i_cfg.data[31:0];
                default: ;
            endcase
        end
    end

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;

    always_comb begin
        if (i_in.byte_count == '0) begin
            sat_count = COUNT_W'(1);
        end else if (i_in.byte_count > LB) begin
            sat_count = LB;
        end else begin
            sat_count = i_in.byte_count;
        end
    end

    // Bytes handled this cycle: the rest of the item or the rest of the block.
    assign rem        = r_count - r_done;
    assign avail      = 7'd64 - {1'b0, r_pos};
    assign chunk      = (avail < {3'd0, rem}) ? avail[COUNT_W-1:0] : rem;
    assign pos_sum    = {1'b0, r_pos} + {3'd0, chunk};
    assign last_chunk = (r_done + chunk) == r_count;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_XOR;
                end
            end
            S_XOR: begin
                if (!r_ksv) begin
                    n_state = S_GEN;
                end else if (last_chunk) begin
                    n_state = S_OUT;
                end
            end
            S_GEN: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (blk_stat.done) begin
                    n_state = S_XOR;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        logic [5:0] kidx;
        i_in.ready    = (r_state == S_IDLE);
        blk_req.start = (r_state == S_GEN);
        blk_req.init  = make_init(r_key0, r_key1, r_key2, r_key3, r_nonce0, r_nonce1, r_ctr);

        n_data  = r_data;
        n_count = r_count;
        n_done  = r_done;
        n_res   = r_res;
        n_ctr   = r_ctr;
        n_pos   = r_pos;
        n_ksv   = r_ksv;
        n_ov    = r_ov;
        n_cb    = r_cb;
        n_cc    = r_cc;
        kidx    = '0;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_data  = i_in.data_bytes;
                    n_count = sat_count;
                    n_done  = '0;
                    n_res   = '0;
                    if (i_in.first_of_message) begin
                        n_ctr = r_ictr;
                        n_pos = '0;
                        n_ksv = 1'b0;
                    end
                end
            end
            S_XOR: begin
                if (r_ksv) begin
                    for (int j = 0; j < LANE_BYTES; j++) begin
                        if (COUNT_W'(j) >= r_done && COUNT_W'(j) < r_done + chunk) begin
                            kidx = r_pos + 6'(COUNT_W'(j) - r_done);
                            n_res[j*8 +: 8] = r_data[j*8 +: 8] ^ ks_flat[kidx*8 +: 8];
                        end
                    end
                    n_done = r_done + chunk;
                    n_pos  = pos_sum[5:0];
                    // Block used up: the next byte needs a fresh block.
                    if (pos_sum[6]) begin
                        n_ksv = 1'b0;
                    end
                end
            end
            S_WAIT: begin
                if (blk_stat.done) begin
                    n_ksv = 1'b1;
                    n_ctr = r_ctr + 32'd1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_ov = 1'b1;
                    n_cb = r_res;
                    n_cc = r_count;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctr   <= '0;
            r_pos   <= '0;
            r_ksv   <= 1'b0;
            r_ov    <= 1'b0;
            r_done  <= '0;
            r_count <= COUNT_W'(1);
        end else begin
            r_state <= n_state;
            r_ctr   <= n_ctr;
            r_pos   <= n_pos;
            r_ksv   <= n_ksv;
            r_ov    <= n_ov;
            r_done  <= n_done;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_res  <= n_res;
        r_cb   <= n_cb;
        r_cc   <= n_cc;
    end

    assign o_out.valid        = r_ov;
    assign o_out.cipher_bytes = r_cb;
    assign o_out.cipher_count = r_cc;

    a_ksv_from_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ksv) |-> $past(blk_stat.done))
        else $error("keystream marked valid without a finished block");

    a_start_needs_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        blk_req.start |-> !r_ksv && !blk_stat.busy)
        else $error("block requested while one is valid or in progress");

    a_done_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done <= r_count && r_count <= LB && r_count != '0)
        else $error("byte progress out of range");

endmodule

### tb/tb_chacha20_stream_cipher_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chacha20_stream_cipher_core
// Self-checking bench for the ChaCha20 stream cipher core. A directed table
// covers reset defaults, count saturation, short items and counter wrap. Random
// messages follow under several key, nonce and counter settings. A predictor
// inside the bench computes every expected byte; directed rows give the counts.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_cipher_core;
    import cc20_pkg::*;

    localparam int ROUNDS          = 20;
    localparam int LANE_BYTES      = 8;
    localparam int IDLE_LIMIT      = 2000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 140;
    localparam int SETTLE_CYCLES   = 60;

    // Index 7 has no register behind it; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    typedef struct packed {
        logic [63:0] bytes;
        logic [3:0]  count;
    } t_cipher_item;

    // One full register setting; mask bit i selects register index i.
    typedef struct packed {
        logic [63:0] key0;
        logic [63:0] key1;
        logic [63:0] key2;
        logic [63:0] key3;
        logic [63:0] nonce0;
        logic [31:0] nonce1;
        logic [31:0] ictr;
        logic [6:0]  mask;
    } t_reg_set;

    typedef enum logic [1:0] {
        SET_NONE,
        SET_RFC,
        SET_ONES,
        SET_KEY_ZERO
    } t_set_sel;

    typedef struct packed {
        t_set_sel    regs;
        logic [63:0] data;
        logic [3:0]  count;
        logic        first;
        logic [3:0]  want_count;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    cc20_cfg_if cfg_ch ();
    cc20_in_if  msg_ch ();
    cc20_out_if res_ch ();

    chacha20_stream_cipher_core #(
        .ROUNDS     (ROUNDS),
        .LANE_BYTES (LANE_BYTES)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (msg_ch),
        .o_out   (res_ch)
    );

    // Predictor state.
    t_reg_set    cur_regs = '0;
    t_words      ks_words = '0;
    logic [31:0] blk_ctr  = '0;
    logic [5:0]  ks_pos   = '0;
    logic        ks_live  = 1'b0;

    t_cipher_item cipher_expect[$];

    int   burst_left   = 0;
    int   gap_max      = 0;
    int   rx_stall_max = 0;
    int   rx_left      = 0;
    logic rx_stalling  = 1'b0;
    int   items_sent   = 0;
    int   mismatches   = 0;
    int   idle_cycles  = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
        logic [63:0] twice;
        twice = {v, v} >> (32 - s);
        return twice[31:0];
    endfunction

    function automatic t_words chacha_block(input t_reg_set r, input logic [31:0] ctr);
        t_words start;
        t_words w;
        int     rnd, q, a, b, c, d, i;
        start = {r.nonce1, r.nonce0, ctr, r.key3, r.key2, r.key1, r.key0,
                 SIGMA3, SIGMA2, SIGMA1, SIGMA0};
        w = start;
        for (rnd = 0; rnd < ROUNDS; rnd++) begin
            for (q = 0; q < 4; q++) begin
                a = q;
                if (rnd % 2 == 0) begin
                    b = q + 4;
                    c = q + 8;
                    d = q + 12;
                end else begin
                    b = 4 + (q + 1) % 4;
                    c = 8 + (q + 2) % 4;
                    d = 12 + (q + 3) % 4;
                end
                w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 16);
                w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 12);
                w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 8);
                w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 7);
            end
        end
        for (i = 0; i < 16; i++) begin
            w[i] = w[i] + start[i];
        end
        return w;
    endfunction

    // Encrypts one item and advances the keystream position. A new block is
    // made only when its first byte is needed, so register writes take effect
    // at the next block boundary.
    function automatic t_cipher_item predict_cipher(input logic [63:0] data,
                                                   input logic [3:0] cnt,
                                                   input logic first);
        t_cipher_item res;
        int           n, i;
        logic [7:0]   ks_byte;
        n = (cnt == 0) ? 1 : ((cnt > LANE_BYTES) ? LANE_BYTES : cnt);
        if (first) begin
            blk_ctr = cur_regs.ictr;
            ks_pos  = '0;
            ks_live = 1'b0;
        end
        res.bytes = '0;
        res.count = n[3:0];
        for (i = 0; i < n; i++) begin
            if (!ks_live) begin
                ks_words = chacha_block(cur_regs, blk_ctr);
                blk_ctr  = blk_ctr + 1'b1;
                ks_live  = 1'b1;
            end
            ks_byte = ks_words[ks_pos[5:2]][{ks_pos[1:0], 3'b000} +: 8];
            res.bytes[8*i +: 8] = data[8*i +: 8] ^ ks_byte;
            ks_pos = ks_pos + 1'b1;
            if (ks_pos == 0) begin
                ks_live = 1'b0;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        case (idx)
            CFG_KEY0:   cur_regs.key0   = value;
            CFG_KEY1:   cur_regs.key1   = value;
            CFG_KEY2:   cur_regs.key2   = value;
            CFG_KEY3:   cur_regs.key3   = value;
            CFG_NONCE0: cur_regs.nonce0 = value;
            CFG_NONCE1: cur_regs.nonce1 = value[31:0];
            CFG_ICTR:   cur_regs.ictr   = value[31:0];
            default: ;
        endcase
    endtask

    // The 32-bit registers get random upper bits, which must be dropped.
    task automatic load_regs(input t_reg_set s);
        if (s.mask[CFG_KEY0])   write_reg(CFG_KEY0, s.key0);
        if (s.mask[CFG_KEY1])   write_reg(CFG_KEY1, s.key1);
        if (s.mask[CFG_KEY2])   write_reg(CFG_KEY2, s.key2);
        if (s.mask[CFG_KEY3])   write_reg(CFG_KEY3, s.key3);
        if (s.mask[CFG_NONCE0]) write_reg(CFG_NONCE0, s.nonce0);
        if (s.mask[CFG_NONCE1]) write_reg(CFG_NONCE1, {$urandom, s.nonce1});
        if (s.mask[CFG_ICTR])   write_reg(CFG_ICTR, {$urandom, s.ictr});
        if (s.mask == 7'h7f)    write_reg(CFG_SPARE, {$urandom, $urandom});
        cfg_ch.valid <= 1'b0;
    endtask

    // The sender works in bursts; valid drops only at the start of a gap or in a drain.
    task automatic send_item(input logic [63:0] data, input logic [3:0] cnt,
                             input logic first, input logic typed,
                             input logic [3:0] typed_cnt);
        t_cipher_item want;
        int           gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                msg_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        msg_ch.valid            <= 1'b1;
        msg_ch.data_bytes       <= data;
        msg_ch.byte_count       <= cnt;
        msg_ch.first_of_message <= first;
        @(posedge i_clk);
        while (msg_ch.ready !== 1'b1) @(posedge i_clk);
        want = predict_cipher(data, cnt, first);
        if (typed) begin
            want.count = typed_cnt;
        end
        cipher_expect.push_back(want);
        burst_left--;
        items_sent++;
    endtask

    task automatic drain_results();
        msg_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (cipher_expect.size() != 0);
    endtask

    // Result checker and receiver stall pattern.
    always @(posedge i_clk) begin
        t_cipher_item want;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (cipher_expect.size() == 0) begin
                report_mismatch("result with no item pending", res_ch.cipher_bytes, '0);
            end else begin
                want = cipher_expect.pop_front();
                if (res_ch.cipher_bytes !== want.bytes) begin
                    report_mismatch("cipher_bytes", res_ch.cipher_bytes, want.bytes);
                end
                if (res_ch.cipher_count !== want.count) begin
                    report_mismatch("cipher_count", {60'h0, res_ch.cipher_count},
                                    {60'h0, want.count});
                end
            end
        end
        if (rx_left == 0) begin
            rx_stalling = !rx_stalling && (rx_stall_max != 0);
            rx_left = rx_stalling ? $urandom_range(1, rx_stall_max) : $urandom_range(1, 12);
        end
        rx_left--;
        res_ch.ready <= !rx_stalling;
    end

    always @(posedge i_clk) begin
        if ((msg_ch.valid && msg_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_dir_row   rows[$];
        t_reg_set   regs;
        int         p, k, kind, len, phase_end;
        logic [3:0] item_cnt;

        i_rst_n                 <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= '0;
        cfg_ch.data             <= '0;
        msg_ch.valid            <= 1'b0;
        msg_ch.data_bytes       <= '0;
        msg_ch.byte_count       <= '0;
        msg_ch.first_of_message <= 1'b0;

        // Reset values first: no first mark, so counter 0 with an all-zero key.
        rows.push_back(t_dir_row'{SET_NONE, 64'h0, 4'd8, 1'b0, 4'd8});
        rows.push_back(t_dir_row'{SET_NONE, '1, 4'd8, 1'b0, 4'd8});
        rows.push_back(t_dir_row'{SET_NONE, 64'hA5A5_A5A5_A5A5_A5A5, 4'd0, 1'b0, 4'd1});
        rows.push_back(t_dir_row'{SET_NONE, '1, 4'd15, 1'b0, 4'd8});
        rows.push_back(t_dir_row'{SET_NONE, '1, 4'd3, 1'b0, 4'd3});
        rows.push_back(t_dir_row'{SET_NONE, 64'h0123_4567_89AB_CDEF, 4'd8, 1'b0, 4'd8});
        rows.push_back(t_dir_row'{SET_NONE, '1, 4'd9, 1'b1, 4'd8});
        // Standard key 00..1f, nonce with 0x4a, counter 1: "Ladies and Gentl".
        rows.push_back(t_dir_row'{SET_RFC, 64'h6120_7365_6964_614C, 4'd8, 1'b1, 4'd8});
        rows.push_back(t_dir_row'{SET_NONE, 64'h6C74_6E65_4720_646E, 4'd8, 1'b0, 4'd8});
        rows.push_back(t_dir_row'{SET_NONE, 64'h0, 4'd1, 1'b0, 4'd1});
        // All ones with the counter at its top value: the second block wraps to 0.
        rows.push_back(t_dir_row'{SET_ONES, '1, 4'd8, 1'b1, 4'd8});
        for (k = 0; k < 8; k++) begin
            rows.push_back(t_dir_row'{SET_NONE, (k % 2 == 0) ? 64'h0 : '1, 4'd8, 1'b0, 4'd8});
        end
        // Key rewritten mid-message; the message goes on without a first mark.
        rows.push_back(t_dir_row'{SET_KEY_ZERO, 64'h5555_5555_5555_5555, 4'd8, 1'b0, 4'd8});
        rows.push_back(t_dir_row'{SET_NONE, 64'hAAAA_AAAA_AAAA_AAAA, 4'd8, 1'b0, 4'd8});
        rows.push_back(t_dir_row'{SET_NONE, '1, 4'd4, 1'b0, 4'd4});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        gap_max      = 3;
        rx_stall_max = 4;
        foreach (rows[r]) begin
            if (rows[r].regs != SET_NONE) begin
                drain_results();
                case (rows[r].regs)
                    SET_RFC: begin
                        regs.key0   = 64'h0706_0504_0302_0100;
                        regs.key1   = 64'h0F0E_0D0C_0B0A_0908;
                        regs.key2   = 64'h1716_1514_1312_1110;
                        regs.key3   = 64'h1F1E_1D1C_1B1A_1918;
                        regs.nonce0 = 64'h4A00_0000_0000_0000;
                        regs.nonce1 = 32'h0;
                        regs.ictr   = 32'h1;
                        regs.mask   = 7'h7f;
                    end
                    SET_ONES: regs = '1;
                    default: begin
                        regs      = '0;
                        regs.mask = 7'h0f;
                    end
                endcase
                load_regs(regs);
            end
            send_item(rows[r].data, rows[r].count, rows[r].first, 1'b1, rows[r].want_count);
        end

        for (p = 0; p < PHASES; p++) begin
            drain_results();
            regs.key0   = {$urandom, $urandom};
            regs.key1   = {$urandom, $urandom};
            regs.key2   = {$urandom, $urandom};
            regs.key3   = {$urandom, $urandom};
            regs.nonce0 = {$urandom, $urandom};
            regs.nonce1 = $urandom;
            regs.ictr   = $urandom;
            // Odd phases but the last rewrite a random set of registers and may carry on a message.
            regs.mask   = (p % 2 == 0) ? 7'h7f : 7'($urandom_range(1, 127));
            if ($urandom_range(0, 2) == 0) begin
                regs.ictr = 32'hFFFF_FFFF - $urandom_range(0, 2);
            end
            if (p == 0) begin
                regs = '1;
            end else if (p == PHASES - 1) begin
                regs      = '0;
                regs.mask = 7'h7f;
            end
            load_regs(regs);

            case (p % 3)
                0: gap_max = 0;
                1: gap_max = 2;
                default: gap_max = 10;
            endcase
            case ((p / 3) % 3)
                0: rx_stall_max = 0;
                1: rx_stall_max = 4;
                default: rx_stall_max = 25;
            endcase

            phase_end = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                kind = $urandom_range(0, 9);
                if (kind == 0) begin
                    send_item({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                              $urandom_range(0, 1) == 1, 1'b0, 4'd0);
                end else begin
                    len = $urandom_range(1, 24);
                    for (k = 0; k < len; k++) begin
                        item_cnt = 4'd8;
                        if (k == len - 1) begin
                            item_cnt = 4'($urandom_range(1, 8));
                        end else if (kind == 1 && $urandom_range(0, 3) == 0) begin
                            item_cnt = 4'($urandom_range(1, 7));
                        end
                        send_item({$urandom, $urandom}, item_cnt,
                                  (k == 0) && ($urandom_range(0, 9) != 0), 1'b0, 4'd0);
                    end
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/cc20_pkg.sv
rtl/cc20_ifs.sv
rtl/cc20_qround.sv
rtl/cc20_core.sv
rtl/chacha20_stream_cipher_core.sv
tb/tb_chacha20_stream_cipher_core.sv
